FILE: src/tsp_pkg.sv
`timescale 1ns / 1ps

package tsp_pkg;

	// plane table size and the widths that follow from it
	localparam int MAX_PLANES = 4096;
	localparam int IDX_W      = $clog2(MAX_PLANES);
	localparam int QW         = IDX_W + 1;
	localparam int LW         = QW + 1;

	// fixed field and register widths
	localparam int Z_W       = 32;
	localparam int SPC_W     = 31;
	localparam int CNT_W     = 13;
	localparam int REM_W     = Z_W;
	localparam int SHW       = SPC_W + QW;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE    = 2'd0,
		CFG_SPACING = 2'd1,
		CFG_COUNT   = 2'd2
	} cfg_reg_t;

	// one operand of the height divider
	typedef struct packed {
		logic             neg;
		logic             sat;
		logic [REM_W-1:0] rem;
		logic [QW-1:0]    quo;
	} lane_t;

	// per-item flags that ride along with the divider
	typedef struct packed {
		logic no_hit;
		logic top_eq_mid;
	} side_t;

	// one restoring step: try to take spacing << k out of the remainder
	function automatic lane_t div_step(lane_t l, logic [SPC_W-1:0] d, int k);
		logic [SHW-1:0] dsh;
		logic [SHW-1:0] rext;
		lane_t          r;
		r    = l;
		dsh  = SHW'(d) << k;
		rext = SHW'(l.rem);
		if (!l.neg && !l.sat && (rext >= dsh)) begin
			r.rem    = l.rem - dsh[REM_W-1:0];
			r.quo[k] = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: src/tsp_front.sv
`timescale 1ns / 1ps

module tsp_front import tsp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [Z_W-1:0]   vertex_z_a,
	input  logic signed [Z_W-1:0]   vertex_z_b,
	input  logic signed [Z_W-1:0]   vertex_z_c,
	input  logic signed [Z_W-1:0]   plane_base,
	input  logic [SPC_W-1:0]        plane_spacing,
	input  logic [CNT_W-1:0]        plane_count,
	output logic                    out_valid,
	input  logic                    out_ready,
	output side_t                   out_side,
	output lane_t                   out_a,
	output lane_t                   out_c
);

	logic                  v_s1;
	logic signed [Z_W-1:0] lo_s1;
	logic signed [Z_W-1:0] mid_s1;
	logic signed [Z_W-1:0] top_s1;

	logic  v_s2;
	side_t side_s2;
	lane_t a_s2;
	lane_t c_s2;

	logic en_s1;
	logic en_s2;

	logic signed [Z_W-1:0] lo_d;
	logic signed [Z_W-1:0] mid_d;
	logic signed [Z_W-1:0] top_d;
	logic                  a_le_b;
	logic                  a_le_c;
	logic                  b_le_c;

	logic signed [Z_W:0] diff_a;
	logic signed [Z_W:0] diff_c;

	// stall chain
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// three-way sort from parallel compares
	always_comb begin
		a_le_b = vertex_z_a <= vertex_z_b;
		a_le_c = vertex_z_a <= vertex_z_c;
		b_le_c = vertex_z_b <= vertex_z_c;
		lo_d  = (a_le_b && a_le_c) ? vertex_z_a : (b_le_c ? vertex_z_b : vertex_z_c);
		top_d = (!a_le_b && !a_le_c) ? vertex_z_a : (!b_le_c ? vertex_z_b : vertex_z_c);
		if (a_le_b == !a_le_c || (a_le_b && a_le_c && !b_le_c && 1'b0)) begin
			mid_d = vertex_z_a;
		end else if (a_le_b != b_le_c || !a_le_b == !b_le_c) begin
			mid_d = (a_le_b == b_le_c) ? vertex_z_b : vertex_z_c;
		end else begin
			mid_d = vertex_z_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			lo_s1  <= lo_d;
			mid_s1 <= mid_d;
			top_s1 <= top_d;
		end
	end

	// heights relative to plane zero
	assign diff_a = {lo_s1[Z_W-1], lo_s1} - {plane_base[Z_W-1], plane_base};
	assign diff_c = {top_s1[Z_W-1], top_s1} - {plane_base[Z_W-1], plane_base};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			side_s2.no_hit     <= (lo_s1 == top_s1) || (plane_spacing == '0) ||
				(plane_count == '0);
			side_s2.top_eq_mid <= top_s1 == mid_s1;
			a_s2.neg <= diff_a[Z_W];
			a_s2.sat <= 1'b0;
			a_s2.rem <= diff_a[REM_W-1:0];
			a_s2.quo <= '0;
			c_s2.neg <= diff_c[Z_W];
			c_s2.sat <= 1'b0;
			c_s2.rem <= diff_c[REM_W-1:0];
			c_s2.quo <= '0;
		end
	end

	assign out_valid = v_s2;
	assign out_side  = side_s2;
	assign out_a     = a_s2;
	assign out_c     = c_s2;

endmodule

FILE: src/tsp_divider.sv
`timescale 1ns / 1ps

module tsp_divider import tsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SPC_W-1:0] plane_spacing,
	input  logic             in_valid,
	output logic             in_ready,
	input  side_t            in_side,
	input  lane_t            in_a,
	input  lane_t            in_c,
	output logic             out_valid,
	input  logic             out_ready,
	output side_t            out_side,
	output lane_t            out_a,
	output lane_t            out_c
);

	// stage 0 checks for quotient overflow, stages 1..QW take one bit each
	logic  v_sk    [QW+1];
	side_t side_sk [QW+1];
	lane_t a_sk    [QW+1];
	lane_t c_sk    [QW+1];
	logic  en_k    [QW+1];

	logic [SHW-1:0] sat_lim;
	lane_t          a_in_d;
	lane_t          c_in_d;

	assign sat_lim = SHW'(plane_spacing) << QW;

	// overflow flags: the quotient would not fit in QW bits
	always_comb begin
		a_in_d     = in_a;
		a_in_d.sat = SHW'(in_a.rem) >= sat_lim;
		c_in_d     = in_c;
		c_in_d.sat = SHW'(in_c.rem) >= sat_lim;
	end

	genvar j;
	generate
		for (j = 0; j <= QW; j++) begin : g_stage
			// stall chain
			if (j == QW) begin : g_last
				assign en_k[j] = !v_sk[j] || out_ready;
			end else begin : g_mid
				assign en_k[j] = !v_sk[j] || en_k[j+1];
			end

			if (j == 0) begin : g_sat
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_sk[j] <= 1'b0;
					end else if (en_k[j]) begin
						v_sk[j] <= in_valid;
					end
				end

				always_ff @(posedge clk) begin
					if (en_k[j] && in_valid) begin
						side_sk[j] <= in_side;
						a_sk[j]    <= a_in_d;
						c_sk[j]    <= c_in_d;
					end
				end
			end else begin : g_step
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						v_sk[j] <= 1'b0;
					end else if (en_k[j]) begin
						v_sk[j] <= v_sk[j-1];
					end
				end

				always_ff @(posedge clk) begin
					if (en_k[j] && v_sk[j-1]) begin
						side_sk[j] <= side_sk[j-1];
						a_sk[j]    <= div_step(a_sk[j-1], plane_spacing, QW - j);
						c_sk[j]    <= div_step(c_sk[j-1], plane_spacing, QW - j);
					end
				end
			end
		end
	endgenerate

	assign in_ready  = en_k[0];
	assign out_valid = v_sk[QW];
	assign out_side  = side_sk[QW];
	assign out_a     = a_sk[QW];
	assign out_c     = c_sk[QW];

endmodule

FILE: src/tsp_resolve.sv
`timescale 1ns / 1ps

module tsp_resolve import tsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] plane_count,
	input  logic             in_valid,
	output logic             in_ready,
	input  side_t            in_side,
	input  lane_t            in_a,
	input  lane_t            in_c,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             hit,
	output logic [IDX_W-1:0] first_plane,
	output logic [IDX_W-1:0] last_plane
);

	logic             v_s1;
	logic             hit_s1;
	logic [IDX_W-1:0] first_s1;
	logic [IDX_W-1:0] last_s1;

	logic [LW-1:0] cnt_cap;
	logic [LW-1:0] last_idx;
	logic [LW-1:0] lo_idx;
	logic [LW-1:0] hi_raw;
	logic [LW-1:0] hi_clamp;
	logic [LW-1:0] hi_fin;
	logic          clamped;
	logic          on_plane;
	logic          hit_d;

	assign in_ready = !v_s1 || out_ready;

	// clamp the plane range and drop a plane that only grazes the top vertex
	always_comb begin
		cnt_cap  = (int'(plane_count) > MAX_PLANES) ? LW'(MAX_PLANES) : LW'(plane_count);
		last_idx = cnt_cap - LW'(1);
		if (in_a.neg) begin
			lo_idx = '0;
		end else if (in_a.sat) begin
			lo_idx = LW'(1) << QW;
		end else begin
			lo_idx = LW'(in_a.quo) + LW'(1);
		end
		hi_raw   = in_c.sat ? (LW'(1) << QW) : LW'(in_c.quo);
		clamped  = hi_raw > last_idx;
		hi_clamp = clamped ? last_idx : hi_raw;
		on_plane = !clamped && (in_c.rem == '0) && !in_side.top_eq_mid;
		hi_fin   = hi_clamp - LW'(on_plane);
		hit_d    = !in_side.no_hit && !in_c.neg && ((lo_idx + LW'(on_plane)) <= hi_clamp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hit_s1   <= hit_d;
			first_s1 <= hit_d ? lo_idx[IDX_W-1:0] : '0;
			last_s1  <= hit_d ? hi_fin[IDX_W-1:0] : '0;
		end
	end

	assign out_valid   = v_s1;
	assign hit         = hit_s1;
	assign first_plane = first_s1;
	assign last_plane  = last_s1;

endmodule

FILE: src/triangle_slice_plane_range_core.sv
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------
// input     | in_valid / in_ready   | vertex_z_a, vertex_z_b, vertex_z_c
// output    | out_valid / out_ready | hit, first_plane, last_plane
// config    | cfg_we                | cfg_idx, cfg_wdata
//
// One item per cycle sustained while out_ready stays high; the restoring divider
// resolves one quotient bit per stage.
// Reset clears all valid bits and loads base 0, spacing 1.0, count 1.
// Each stage holds while its successor is full and stalled; bubbles collapse,
// so new items are taken while a finished result waits at the output.

module triangle_slice_plane_range_core import tsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [Z_W-1:0]        cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [Z_W-1:0] vertex_z_a,
	input  logic signed [Z_W-1:0] vertex_z_b,
	input  logic signed [Z_W-1:0] vertex_z_c,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [IDX_W-1:0]      first_plane,
	output logic [IDX_W-1:0]      last_plane
);

	logic signed [Z_W-1:0] base_q;
	logic [SPC_W-1:0]      spacing_q;
	logic [CNT_W-1:0]      count_q;

	logic  fr_valid;
	logic  fr_ready;
	side_t fr_side;
	lane_t fr_a;
	lane_t fr_c;

	logic  dv_valid;
	logic  dv_ready;
	side_t dv_side;
	lane_t dv_a;
	lane_t dv_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			spacing_q <= SPC_W'(65536);
			count_q   <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BASE:    base_q    <= cfg_wdata;
				CFG_SPACING: spacing_q <= cfg_wdata[SPC_W-1:0];
				CFG_COUNT:   count_q   <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sort and offset from plane zero
	tsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.vertex_z_a    (vertex_z_a),
		.vertex_z_b    (vertex_z_b),
		.vertex_z_c    (vertex_z_c),
		.plane_base    (base_q),
		.plane_spacing (spacing_q),
		.plane_count   (count_q),
		.out_valid     (fr_valid),
		.out_ready     (fr_ready),
		.out_side      (fr_side),
		.out_a         (fr_a),
		.out_c         (fr_c)
	);

	// floor division of both heights by the spacing (non-negative heights only)
	tsp_divider u_divider (
		.clk           (clk),
		.arst_n        (arst_n),
		.plane_spacing (spacing_q),
		.in_valid      (fr_valid),
		.in_ready      (fr_ready),
		.in_side       (fr_side),
		.in_a          (fr_a),
		.in_c          (fr_c),
		.out_valid     (dv_valid),
		.out_ready     (dv_ready),
		.out_side      (dv_side),
		.out_a         (dv_a),
		.out_c         (dv_c)
	);

	// range clamp and output register
	tsp_resolve u_resolve (
		.clk         (clk),
		.arst_n      (arst_n),
		.plane_count (count_q),
		.in_valid    (dv_valid),
		.in_ready    (dv_ready),
		.in_side     (dv_side),
		.in_a        (dv_a),
		.in_c        (dv_c),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.first_plane (first_plane),
		.last_plane  (last_plane)
	);

endmodule
